FILE: rtl/tlef_pkg.sv
// Shared types and constants of the tank level echo filter.
`default_nettype none

package tlef_pkg;

	// Serial divider sizes: the dividend covers echo_us * 17, the divisor covers 1000.
	localparam int unsigned DIV_W   = 20;
	localparam int unsigned DVS_W   = 10;
	localparam int unsigned CNT_W   = 5;

	// Centimeter conversion: floor(echo * 17 / 1000) over all dividend bits.
	localparam logic [DVS_W-1:0] CM_DIVISOR = 10'd1000;
	localparam logic [CNT_W-1:0] CM_STEPS   = 5'd20;
	// Percent division uses only the upper 16 dividend bits.
	localparam logic [CNT_W-1:0] PCT_STEPS  = 5'd16;

	localparam logic [8:0] MAX_DIST_CM = 9'd510;
	localparam logic [6:0] PCT_FULL    = 7'd100;
	localparam logic [2:0] ERR_MAX     = 3'd7;

	// Configuration register indexes.
	localparam logic [2:0] REG_JUMP_LIMIT  = 3'd0;
	localparam logic [2:0] REG_ERROR_LIMIT = 3'd1;
	localparam logic [2:0] REG_EMPTY_CM    = 3'd2;
	localparam logic [2:0] REG_FULL_CM     = 3'd3;
	localparam logic [2:0] REG_LITERS      = 3'd4;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] steps;
	} sdiv_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/tlef_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module tlef_sdiv (
	input  wire                     clk,
	input  wire                     arst_n,
	input  tlef_pkg::sdiv_ctl_t     ctl,
	input  wire [tlef_pkg::DIV_W-1:0] dividend,
	input  wire [tlef_pkg::DVS_W-1:0] divisor,
	output logic                    done,
	output logic [tlef_pkg::DIV_W-1:0] quotient
);
	import tlef_pkg::*;

	logic [DIV_W-1:0] num_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic             fits;

	// The shifted remainder stays below twice the divisor, so one compare decides the bit.
	assign trial = {rem_q, num_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				cnt_q <= ctl.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/tank_level_echo_filter.sv
// Top level of the tank level echo filter.
//
// Input channel s_*: one transaction per echo reading, echo_us in s_tdata, relay_on and
// auto_mode in s_tuser. Output channel m_*: one transaction per reading with the
// filtered distance, fill percent, usage increment and the two status flags.
// Config write port cfg_we/cfg_index/cfg_data: user writes it while idle; not enforced.
//
// A reading runs through one shared bit-serial divider twice: 20 steps for the
// centimeter conversion, then 16 steps for the fill percent, while the usage product
// is built by a shift-add over the 8 bits of the volume-per-centimeter register.
// The result is registered in ST_FINISH once the output register is free. A new
// reading is taken only after the last one is through, since the input opens as the
// result is registered.
//
// s_tready is high whenever no reading is in work, even while a result still waits in
// the output register. If the receiver stalls, a finished reading waits for the output
// register to free up. Reset clears the filter state, returns the registers to their
// defaults and drops m_tvalid.
`default_nettype none

module tank_level_echo_filter #(
	parameter int unsigned ECHO_TIMEOUT_US = 30000
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [15:0] s_tdata,   // [14:0] echo_us, [15] zero
	input  wire [1:0]  s_tuser,   // [0] relay_on, [1] auto_mode
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [39:0] m_tdata,  // [8:0] distance_cm, [15:9] level_percent,
	                              // [32:16] usage_add, [39:33] zero
	output logic [1:0] m_tuser,   // [0] distance_valid, [1] safety_shutoff
	input  wire        cfg_we,
	input  wire [2:0]  cfg_index,
	input  wire [8:0]  cfg_data
);
	import tlef_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_CM,
		ST_FILTER,
		ST_PCT_START,
		ST_PCT,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [8:0] jump_q, empty_q, full_q;
	logic [2:0] errlim_q;
	logic [7:0] liters_q;

	logic       echo_ok_q, relay_q, auto_q;
	logic       hv_q, ht_q, shut_q;
	logic [8:0] valid_q, tracked_q, diff_q;
	logic [2:0] err_q;
	logic [6:0] held_q;
	logic [16:0] acc_q;
	logic [3:0] mcnt_q;

	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic       in_acc;
	logic [14:0] echo;
	logic [16:0] echo_ext;
	logic [DIV_W-1:0] echo17;

	sdiv_ctl_t        div_ctl;
	logic [DIV_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;

	logic [8:0]  pct_x;
	logic [15:0] pct_num;

	// Filter step results
	logic [8:0] raw;
	logic [8:0] jdiff;
	logic       f_hv, f_lost;
	logic [8:0] f_valid;
	logic [2:0] f_err;
	logic [6:0] lvl;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign echo     = s_tdata[14:0];
	assign echo_ext = {2'b00, echo};
	assign echo17   = (DIV_W'(echo) << 4) + DIV_W'(echo);
	assign out_free = !m_tvalid_q || m_tready;

	assign pct_x   = empty_q - valid_q;
	assign pct_num = (16'(pct_x) << 6) + (16'(pct_x) << 5) + (16'(pct_x) << 2);

	always_comb begin
		div_ctl.start = in_acc || (state_q == ST_PCT_START);
		div_ctl.steps = (state_q == ST_IDLE) ? CM_STEPS : PCT_STEPS;
		if (state_q == ST_IDLE) begin
			div_dividend = echo17;
			div_divisor  = CM_DIVISOR;
		end else begin
			div_dividend = {pct_num, 4'b0000};
			div_divisor  = {1'b0, empty_q - full_q};
		end
	end

	tlef_sdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Accept or reject the converted distance, then check for lost tracking.
	always_comb begin
		raw     = (div_quo > DIV_W'(MAX_DIST_CM)) ? MAX_DIST_CM : div_quo[8:0];
		jdiff   = (raw > valid_q) ? raw - valid_q : valid_q - raw;
		f_hv    = hv_q;
		f_valid = valid_q;
		f_err   = err_q;
		if (!hv_q) begin
			if (echo_ok_q && raw != 9'd0) begin
				f_hv    = 1'b1;
				f_valid = raw;
				f_err   = 3'd0;
			end
		end else if (echo_ok_q && raw != 9'd0 && jdiff <= jump_q) begin
			f_valid = raw;
			f_err   = 3'd0;
		end else if (err_q < ERR_MAX) begin
			f_err = err_q + 3'd1;
		end
		f_lost = (f_err >= errlim_q);
		if (f_lost) begin
			f_hv    = 1'b0;
			f_valid = 9'd0;
		end
	end

	always_comb begin
		if (!hv_q) begin
			lvl = held_q;
		end else if (valid_q >= empty_q) begin
			lvl = 7'd0;
		end else if (valid_q <= full_q) begin
			lvl = PCT_FULL;
		end else begin
			lvl = div_quo[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_q   <= 9'd15;
			errlim_q <= 3'd5;
			empty_q  <= 9'd100;
			full_q   <= 9'd20;
			liters_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_JUMP_LIMIT:  jump_q   <= cfg_data;
				REG_ERROR_LIMIT: errlim_q <= cfg_data[2:0];
				REG_EMPTY_CM:    empty_q  <= cfg_data;
				REG_FULL_CM:     full_q   <= cfg_data;
				REG_LITERS:      liters_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hv_q       <= 1'b0;
			valid_q    <= 9'd0;
			ht_q       <= 1'b0;
			tracked_q  <= 9'd0;
			err_q      <= 3'd0;
			held_q     <= 7'd0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
			echo_ok_q  <= 1'b0;
			relay_q    <= 1'b0;
			auto_q     <= 1'b0;
			shut_q     <= 1'b0;
			diff_q     <= 9'd0;
			acc_q      <= 17'd0;
			mcnt_q     <= 4'd0;
		end else begin
			// In ST_FINISH the output register is either refilled or still stalled.
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						echo_ok_q <= (echo != 15'd0) && (echo_ext <= 17'(ECHO_TIMEOUT_US));
						relay_q   <= s_tuser[0];
						auto_q    <= s_tuser[1];
						state_q   <= ST_DIV_CM;
					end
				end
				ST_DIV_CM: begin
					if (div_done) begin
						state_q <= ST_FILTER;
					end
				end
				ST_FILTER: begin
					hv_q    <= f_hv;
					valid_q <= f_valid;
					err_q   <= f_err;
					shut_q  <= f_lost && relay_q && auto_q;
					if (f_lost) begin
						ht_q      <= 1'b0;
						tracked_q <= 9'd0;
					end
					state_q <= ST_PCT_START;
				end
				ST_PCT_START: begin
					acc_q  <= 17'd0;
					mcnt_q <= 4'd0;
					diff_q <= 9'd0;
					if (hv_q) begin
						if (!ht_q || relay_q) begin
							ht_q      <= 1'b1;
							tracked_q <= valid_q;
						end else if (10'(valid_q) >= 10'(tracked_q) + 10'd2) begin
							diff_q    <= valid_q - tracked_q;
							tracked_q <= valid_q;
						end else if (10'(valid_q) + 10'd2 <= 10'(tracked_q)) begin
							tracked_q <= valid_q;
						end
					end
					state_q <= ST_PCT;
				end
				ST_PCT: begin
					// Shift-add usage product, one bit of the volume per centimeter each cycle.
					if (!mcnt_q[3]) begin
						if (liters_q[mcnt_q[2:0]]) begin
							acc_q <= acc_q + (17'(diff_q) << mcnt_q[2:0]);
						end
						mcnt_q <= mcnt_q + 4'd1;
					end
					if (div_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						held_q     <= lvl;
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {7'd0, acc_q, lvl, valid_q};
						m_tuser_q  <= {shut_q, hv_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench of the tank level echo filter: predicted reports against DUT output.
`timescale 1ns / 1ps

import tlef_pkg::*;

localparam int unsigned TIMEOUT_US = 30000;

typedef struct packed {
	logic        dist_valid;
	logic [8:0]  dist_cm;
	logic [6:0]  percent;
	logic [16:0] usage;
	logic        shutoff;
} tank_report_t;

// Keeps a shadow of the filter state and the registers, and the reports still owed.
class tank_reading_board;
	logic [8:0]   jump_cm, empty_at_cm, full_at_cm;
	logic [2:0]   err_limit;
	logic [7:0]   vol_per_cm;
	bit           locked, have_ref;
	logic [8:0]   last_good_cm, usage_ref_cm;
	logic [2:0]   reject_count;
	logic [6:0]   shown_percent;
	tank_report_t expected_reports[$];
	int unsigned  errors;

	function new();
		jump_cm = 9'd15;
		err_limit = 3'd5;
		empty_at_cm = 9'd100;
		full_at_cm = 9'd20;
		vol_per_cm = 8'd1;
		locked = 1'b0;
		have_ref = 1'b0;
		last_good_cm = '0;
		usage_ref_cm = '0;
		reject_count = '0;
		shown_percent = '0;
		errors = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [8:0] value);
		case (idx)
			REG_JUMP_LIMIT:  jump_cm = value;
			REG_ERROR_LIMIT: err_limit = value[2:0];
			REG_EMPTY_CM:    empty_at_cm = value;
			REG_FULL_CM:     full_at_cm = value;
			REG_LITERS:      vol_per_cm = value[7:0];
			default: ;
		endcase
	endfunction

	function int unsigned fill_percent(int unsigned d);
		int unsigned e, f;
		e = 32'(empty_at_cm);
		f = 32'(full_at_cm);
		if (d >= e) return 0;
		if (d <= f) return 32'(PCT_FULL);
		return ((e - d) * 100) / (e - f);
	endfunction

	function void note_reading(logic [14:0] echo, bit relay_on, bit auto_mode);
		int unsigned e, raw, diff, d, usage;
		bit ok, shutoff;
		tank_report_t rep;
		usage = 0;
		shutoff = 1'b0;
		e = 32'(echo);
		ok = (e != 0) && (e <= TIMEOUT_US);
		raw = (e * 17) / 1000;
		if (raw > MAX_DIST_CM) raw = 32'(MAX_DIST_CM);
		ok = ok && (raw > 0);

		if (!locked) begin
			if (ok) begin
				locked = 1'b1;
				last_good_cm = 9'(raw);
				reject_count = '0;
			end
		end else begin
			diff = (raw > last_good_cm) ? raw - last_good_cm : last_good_cm - raw;
			if (ok && diff <= jump_cm) begin
				last_good_cm = 9'(raw);
				reject_count = '0;
			end else if (reject_count < ERR_MAX) begin
				reject_count++;
			end
		end

		// Losing the lock repeats on every reading while the count stays at the limit.
		if (reject_count >= err_limit) begin
			locked = 1'b0;
			last_good_cm = '0;
			have_ref = 1'b0;
			usage_ref_cm = '0;
			shutoff = relay_on && auto_mode;
		end

		if (locked) begin
			d = 32'(last_good_cm);
			shown_percent = 7'(fill_percent(d));
			if (!have_ref || relay_on) begin
				have_ref = 1'b1;
				usage_ref_cm = 9'(d);
			end else if (d >= usage_ref_cm + 2) begin
				usage = (d - usage_ref_cm) * vol_per_cm;
				usage_ref_cm = 9'(d);
			end else if (d + 2 <= usage_ref_cm) begin
				usage_ref_cm = 9'(d);
			end
		end

		rep.dist_valid = locked;
		rep.dist_cm = locked ? last_good_cm : 9'd0;
		rep.percent = shown_percent;
		rep.usage = usage[16:0];
		rep.shutoff = shutoff;
		expected_reports.push_back(rep);
	endfunction

	function void compare_field(string fname, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
		end
	endfunction

	function void check_report(logic [39:0] tdata, logic [1:0] tuser);
		tank_report_t want;
		if (expected_reports.size() == 0) begin
			errors++;
			$display("%0t: report with no reading pending, actual distance_cm %0d",
				$time, tdata[8:0]);
			return;
		end
		want = expected_reports.pop_front();
		compare_field("distance_valid", 32'(want.dist_valid), 32'(tuser[0]));
		compare_field("distance_cm", 32'(want.dist_cm), 32'(tdata[8:0]));
		compare_field("level_percent", 32'(want.percent), 32'(tdata[15:9]));
		compare_field("usage_add", 32'(want.usage), 32'(tdata[32:16]));
		compare_field("safety_shutoff", 32'(want.shutoff), 32'(tuser[1]));
	endfunction
endclass

module tb;
	import tlef_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned LONG_HOLD      = 400;
	localparam int unsigned SETTLE_CYCLES  = 50;
	localparam int unsigned PHASE_ITEMS    = 185;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tready = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [8:0]  cfg_data = '0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [39:0] m_tdata;
	wire  [1:0]  m_tuser;

	tank_reading_board board;
	int unsigned       gap_pct = 0;
	bit                hold_req = 1'b0;
	int                walk_cm = 60;
	int unsigned       quiet_cycles = 0;

	tank_level_echo_filter #(
		.ECHO_TIMEOUT_US(TIMEOUT_US)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Both channels are sampled with their values from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				board.note_reading(s_tdata[14:0], s_tuser[0], s_tuser[1]);
			end
			if (m_tvalid && m_tready) begin
				board.check_report(m_tdata, m_tuser);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_reading(input logic [14:0] echo, input bit relay_on,
			input bit auto_mode);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, echo};
		s_tuser <= {auto_mode, relay_on};
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [8:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		board.set_reg(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_readings();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.expected_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly a random walk of the level within reach of the jump limit, the rest noise.
	task automatic run_random_readings(input int unsigned count, input int unsigned hold_at);
		int unsigned pick, echo, span;
		int step;
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				span = 32'(board.jump_cm) + 3;
				if (span > 60) span = 60;
				step = int'($urandom_range(0, 2 * span)) - int'(span);
				walk_cm = walk_cm + step;
				if (walk_cm < 1) walk_cm = 1;
				if (walk_cm > 510) walk_cm = 510;
				echo = (walk_cm * 1000) / 17 + $urandom_range(0, 58);
				if (echo > TIMEOUT_US) echo = TIMEOUT_US;
			end else if (pick < 80) begin
				echo = 0;
			end else if (pick < 85) begin
				echo = $urandom_range(TIMEOUT_US + 1, 32767);
			end else if (pick < 90) begin
				echo = $urandom_range(1, 58);
			end else begin
				echo = $urandom_range(0, 32767);
			end
			send_reading(echo[14:0], $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
			if (i == hold_at) hold_req = 1'b1;
		end
	endtask

	task automatic run_phase(input logic [8:0] jump, input logic [8:0] err_lim,
			input logic [8:0] empty_at, input logic [8:0] full_at, input logic [8:0] vol,
			input int unsigned gap, input int unsigned count, input int unsigned hold_at);
		drain_readings();
		write_reg(REG_JUMP_LIMIT, jump);
		write_reg(REG_ERROR_LIMIT, err_lim);
		write_reg(REG_EMPTY_CM, empty_at);
		write_reg(REG_FULL_CM, full_at);
		write_reg(REG_LITERS, vol);
		gap_pct = gap;
		walk_cm = $urandom_range(10, 250);
		run_random_readings(count, hold_at);
	endtask

	initial begin
		int unsigned empty_pick;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed readings under the reset settings.
		gap_pct = 20;
		send_reading(15'd0, 1'b0, 1'b0);          // no echo while untracked
		send_reading(15'd30001, 1'b0, 1'b0);      // long echo
		send_reading(15'h7FFF, 1'b1, 1'b1);       // longest echo field value
		send_reading(15'd58, 1'b0, 1'b0);         // echo rounds down to 0 cm
		send_reading(15'd3530, 1'b0, 1'b0);       // first lock at 60 cm
		send_reading(15'd3600, 1'b0, 1'b0);       // rise of 1 cm, no usage
		send_reading(15'd3706, 1'b0, 1'b0);       // rise of 3 cm, usage
		send_reading(15'd3412, 1'b0, 1'b0);       // fall of 5 cm
		send_reading(15'd3800, 1'b1, 1'b1);       // relay on, reference follows
		repeat (5) send_reading(15'd0, 1'b1, 1'b1); // rejections up to the lost lock
		send_reading(15'd0, 1'b1, 1'b1);          // lost again while still at the limit
		send_reading(15'd0, 1'b1, 1'b0);          // lost, manual mode, no shutoff
		send_reading(15'd30000, 1'b0, 1'b1);      // longest accepted echo, exactly 510 cm
		send_reading(15'd29999, 1'b0, 1'b0);
		send_reading(15'd1, 1'b0, 1'b0);          // zero distance while tracked
		send_reading(15'd16384, 1'b1, 1'b0);      // jump too large
		send_reading(15'd29500, 1'b0, 1'b0);
		send_reading(15'd5882, 1'b0, 1'b1);       // 99 cm, just inside empty, rejected as a jump
		send_reading(15'd1176, 1'b0, 1'b0);       // 19 cm, also rejected as a jump

		gap_pct = 0;
		run_random_readings(PHASE_ITEMS, PHASE_ITEMS);

		run_phase(9'd0, 9'd1, 9'd511, 9'd0, 9'd255, 20, PHASE_ITEMS, PHASE_ITEMS);
		run_phase(9'd511, 9'd7, 9'd300, 9'd50, 9'd0, 40, PHASE_ITEMS, PHASE_ITEMS);
		// The error limit write is masked to zero, so the lock is lost on every reading.
		run_phase(9'd15, 9'h008, 9'd100, 9'd20, 9'd3, 20, 50, 50);
		// Full at or above empty, with over-wide limit and volume writes.
		run_phase(9'd20, 9'h1FD, 9'd100, 9'd150, 9'h1FF, 0, PHASE_ITEMS, PHASE_ITEMS);

		empty_pick = $urandom_range(60, 511);
		run_phase(9'($urandom_range(5, 40)), 9'($urandom_range(1, 7)), 9'(empty_pick),
			9'($urandom_range(0, empty_pick - 1)), 9'($urandom_range(0, 255)), 30,
			PHASE_ITEMS, 60);
		run_phase(9'($urandom_range(0, 30)), 9'($urandom_range(1, 7)), 9'd0, 9'd511,
			9'($urandom_range(0, 255)), 20, PHASE_ITEMS, PHASE_ITEMS);
		empty_pick = $urandom_range(60, 511);
		run_phase(9'($urandom_range(5, 40)), 9'($urandom_range(1, 7)), 9'(empty_pick),
			9'($urandom_range(0, empty_pick - 1)), 9'($urandom_range(0, 255)), 40,
			PHASE_ITEMS, PHASE_ITEMS);
		// Closing stretch without idling on either side.
		empty_pick = $urandom_range(60, 511);
		run_phase(9'($urandom_range(5, 40)), 9'($urandom_range(1, 7)), 9'(empty_pick),
			9'($urandom_range(0, empty_pick - 1)), 9'($urandom_range(0, 255)), 0,
			PHASE_ITEMS, PHASE_ITEMS);

		drain_readings();
		if (board.errors == 0 && board.expected_reports.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
